>>> rtl/core/tlb_page_table_lru_mmu_assert.svh
// Assertion macros for the TLB/page-table MMU checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef TLB_PAGE_TABLE_LRU_MMU_ASSERT_SVH
`define TLB_PAGE_TABLE_LRU_MMU_ASSERT_SVH
// same-cycle implication
`define TLBM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlbm assertion failed");
// next-cycle implication
`define TLBM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlbm assertion failed");
`endif

>>> rtl/core/tlbm_pkg.sv
// Package for the TLB/page-table MMU: sizes, codes, payload and control structs.
// No dependencies.
`default_nettype none
package tlbm_pkg;
  localparam int unsigned MAX_PAGES  = 64;
  localparam int unsigned MAX_FRAMES = 32;
  localparam int unsigned TLB_DEPTH  = 16;

  localparam int unsigned PAGE_W  = 7;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 7;

  localparam int unsigned PIDX_W = $clog2(MAX_PAGES);
  localparam int unsigned PCNT_W = $clog2(MAX_PAGES + 1);
  localparam int unsigned FIDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned FCNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned FW_W   = (FCNT_W > 5) ? FCNT_W : 5;
  localparam int unsigned TIDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int unsigned TCNT_W = $clog2(TLB_DEPTH + 1);

  typedef enum logic [2:0] {
    OC_HIT   = 3'd0,
    OC_MISS  = 3'd1,
    OC_FREE  = 3'd2,
    OC_EVICT = 3'd3,
    OC_BAD   = 3'd4,
    OC_START = 3'd5
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES  = 3'd0,
    CFG_WINDOW_START  = 3'd1,
    CFG_WINDOW_FRAMES = 3'd2,
    CFG_TLB_ENTRIES   = 3'd3,
    CFG_PAGE_COUNT    = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_MOD, ST_CLRW, ST_FREE, ST_PFRD,
    ST_LRU, ST_VFRD, ST_TSCAN, ST_INS
  } state_e;

  typedef struct packed {
    logic              command;
    logic [PAGE_W-1:0] page_number;
  } in_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [FRAME_W-1:0] frame_number;
    logic [PAGE_W-1:0]  victim_page;
    logic [CNT_W-1:0]   fault_total;
  } out_t;

  typedef struct packed {
    logic     latch;
    logic     fw_init;
    logic     mod_step;
    logic     fw_step;
    logic     clr_free;
    logic     claim;
    logic     hit_upd;
    logic     rd_pf;
    logic     take_pf;
    logic     lru_init;
    logic     lru_step;
    logic     rd_vf;
    logic     take_vf;
    logic     ts_init;
    logic     ts_step;
    logic     ts_drop;
    logic     insert;
    logic     clr_proc;
    logic     emit;
    outcome_e oc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic bad;
    logic hit;
    logic pvalid;
    logic mod_done;
    logic fw_end;
    logic fw_free;
    logic lru_end;
    logic lru_found;
    logic tlb_full;
    logic ts_end;
  } ctrl_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/tlbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tlbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/tlbm_ctrl.sv
// Sequencer for the TLB/page-table MMU: issues datapath commands.
// Depends on tlbm_pkg.
`default_nettype none
module tlbm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire tlbm_pkg::ctrl_sts_t sts_i,
  output tlbm_pkg::ctrl_cmd_t      cmd_o,
  output logic                     busy_o
);
  tlbm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlbm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.oc = tlbm_pkg::OC_BAD;
    unique case (state_q)
      tlbm_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = tlbm_pkg::ST_LOOK;
        end
      end
      tlbm_pkg::ST_LOOK: begin
        priority if (sts_i.is_start) begin
          cmd_o.fw_init = 1'b1;
          state_d = tlbm_pkg::ST_MOD;
        end else if (sts_i.bad) begin
          cmd_o.emit = 1'b1;
          cmd_o.oc   = tlbm_pkg::OC_BAD;
          state_d = tlbm_pkg::ST_IDLE;
        end else if (sts_i.hit) begin
          cmd_o.hit_upd = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.oc      = tlbm_pkg::OC_HIT;
          state_d = tlbm_pkg::ST_IDLE;
        end else if (sts_i.pvalid) begin
          cmd_o.rd_pf = 1'b1;
          state_d = tlbm_pkg::ST_PFRD;
        end else begin
          cmd_o.fw_init = 1'b1;
          state_d = tlbm_pkg::ST_MOD;
        end
      end
      tlbm_pkg::ST_MOD: begin
        if (!sts_i.mod_done) begin
          cmd_o.mod_step = 1'b1;
        end else if (sts_i.is_start) begin
          state_d = tlbm_pkg::ST_CLRW;
        end else begin
          state_d = tlbm_pkg::ST_FREE;
        end
      end
      tlbm_pkg::ST_CLRW: begin
        if (sts_i.fw_end) begin
          cmd_o.clr_proc = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.oc       = tlbm_pkg::OC_START;
          state_d = tlbm_pkg::ST_IDLE;
        end else begin
          cmd_o.clr_free = 1'b1;
        end
      end
      tlbm_pkg::ST_FREE: begin
        priority if (sts_i.fw_end) begin
          cmd_o.lru_init = 1'b1;
          state_d = tlbm_pkg::ST_LRU;
        end else if (sts_i.fw_free) begin
          cmd_o.claim   = 1'b1;
          cmd_o.ts_init = 1'b1;
          state_d = tlbm_pkg::ST_TSCAN;
        end else begin
          cmd_o.fw_step = 1'b1;
        end
      end
      tlbm_pkg::ST_PFRD: begin
        cmd_o.take_pf = 1'b1;
        cmd_o.ts_init = 1'b1;
        state_d = tlbm_pkg::ST_TSCAN;
      end
      tlbm_pkg::ST_LRU: begin
        if (!sts_i.lru_end) begin
          cmd_o.lru_step = 1'b1;
        end else if (sts_i.lru_found) begin
          cmd_o.rd_vf = 1'b1;
          state_d = tlbm_pkg::ST_VFRD;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.oc   = tlbm_pkg::OC_BAD;
          state_d = tlbm_pkg::ST_IDLE;
        end
      end
      tlbm_pkg::ST_VFRD: begin
        cmd_o.take_vf = 1'b1;
        cmd_o.ts_init = 1'b1;
        state_d = tlbm_pkg::ST_TSCAN;
      end
      tlbm_pkg::ST_TSCAN: begin
        priority if (!sts_i.tlb_full) begin
          state_d = tlbm_pkg::ST_INS;
        end else if (sts_i.ts_end) begin
          cmd_o.ts_drop = 1'b1;
          state_d = tlbm_pkg::ST_INS;
        end else begin
          cmd_o.ts_step = 1'b1;
        end
      end
      tlbm_pkg::ST_INS: begin
        cmd_o.insert = 1'b1;
        cmd_o.emit   = 1'b1;
        state_d = tlbm_pkg::ST_IDLE;
      end
      default: begin
        state_d = tlbm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != tlbm_pkg::ST_IDLE);
endmodule
`default_nettype wire

>>> rtl/core/tlbm_dp.sv
// Datapath for the TLB/page-table MMU: config, TLB, page table, walks, result.
// Depends on tlbm_pkg and tlbm_ram.
`default_nettype none
module tlbm_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tlbm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tlbm_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire tlbm_pkg::in_t                       in_i,
  input  wire tlbm_pkg::ctrl_cmd_t                 cmd_i,
  output tlbm_pkg::ctrl_sts_t                      sts_o,
  output logic                                     done_o,
  output tlbm_pkg::out_t                           result_o
);
  localparam int unsigned PW  = tlbm_pkg::PAGE_W;
  localparam int unsigned FRW = tlbm_pkg::FRAME_W;
  localparam int unsigned TSW = tlbm_pkg::TS_W;
  localparam int unsigned NP  = tlbm_pkg::MAX_PAGES;
  localparam int unsigned NF  = tlbm_pkg::MAX_FRAMES;
  localparam int unsigned NT  = tlbm_pkg::TLB_DEPTH;

  // configuration
  logic [5:0] tot_q, wfr_q;
  logic [4:0] wst_q, tle_q;
  logic [6:0] pcnt_q;

  logic [tlbm_pkg::FCNT_W-1:0] eff_frames, eff_win;
  logic [tlbm_pkg::TCNT_W-1:0] cap;
  logic [PW-1:0]               limit;

  always_comb begin
    int unsigned ef, ew, ct, lm;
    ef = (tot_q == '0) ? 1 : ((32'(tot_q) > NF) ? NF : 32'(tot_q));
    ew = (32'(wfr_q) < ef) ? 32'(wfr_q) : ef;
    ct = (tle_q == '0) ? 1 : ((32'(tle_q) > NT) ? NT : 32'(tle_q));
    lm = (32'(pcnt_q) > NP) ? NP : 32'(pcnt_q);
    eff_frames = tlbm_pkg::FCNT_W'(ef);
    eff_win    = tlbm_pkg::FCNT_W'(ew);
    cap        = tlbm_pkg::TCNT_W'(ct);
    limit      = PW'(lm);
  end

  // latched item
  logic          cmd_q;
  logic [PW-1:0] pg_q;
  logic [tlbm_pkg::PIDX_W-1:0] p_idx;
  assign p_idx = tlbm_pkg::PIDX_W'(pg_q - PW'(1));

  // state
  logic [PW-1:0]  tlb_pg_q [NT];
  logic [FRW-1:0] tlb_fr_q [NT];
  logic [TSW-1:0] tlb_ts_q [NT];
  logic [NT-1:0]  tlb_v_q;
  logic [NP-1:0]  pv_q;
  logic [NF-1:0]  ff_q;
  logic [tlbm_pkg::CNT_W-1:0] fault_q;
  logic [TSW-1:0] time_q, now;
  assign now = (time_q == '1) ? time_q : time_q + TSW'(1);

  // walks
  logic [tlbm_pkg::FW_W-1:0]   fw_f_q;
  logic [tlbm_pkg::FCNT_W-1:0] fw_cnt_q;
  logic [tlbm_pkg::PCNT_W-1:0] lru_addr_q;
  logic                        lru_rv_q, lru_found_q;
  logic [tlbm_pkg::PIDX_W-1:0] lru_idx_q, lru_best_q;
  logic [TSW-1:0]              lru_bt_q;
  logic [tlbm_pkg::TCNT_W-1:0] ts_idx_q;
  logic                        ts_found_q;
  logic [tlbm_pkg::TIDX_W-1:0] ts_best_q, ts_idx;
  logic [TSW-1:0]              ts_bt_q;

  logic [FRW-1:0]      fr_q;
  logic [PW-1:0]       vict_q;
  tlbm_pkg::outcome_e  oc_q;

  assign ts_idx = ts_idx_q[tlbm_pkg::TIDX_W-1:0];

  // TLB match, victim match, first free slot
  logic [NT-1:0]               hit_vec, vmatch;
  logic [tlbm_pkg::TIDX_W-1:0] hit_idx, ins_idx;
  logic                        ins_ok;
  logic [PW-1:0]               lru_page;
  assign lru_page = PW'(lru_best_q) + PW'(1);

  always_comb begin
    hit_idx = '0;
    ins_idx = '0;
    ins_ok  = 1'b0;
    for (int i = 0; i < NT; i++) begin
      hit_vec[i] = tlb_v_q[i] && (tlb_pg_q[i] == pg_q);
      vmatch[i]  = tlb_v_q[i] && (tlb_pg_q[i] == lru_page);
    end
    for (int i = NT - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = tlbm_pkg::TIDX_W'(i);
      if (!tlb_v_q[i]) begin
        ins_idx = tlbm_pkg::TIDX_W'(i);
        ins_ok  = 1'b1;
      end
    end
  end

  // memories
  logic [FRW-1:0] fr_rdata;
  logic [TSW-1:0] ts_rdata;
  logic           lru_issue;
  assign lru_issue = cmd_i.lru_step && (lru_addr_q != tlbm_pkg::PCNT_W'(NP));

  tlbm_ram #(.Width(FRW), .Depth(NP)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (p_idx),
    .wdata_i (fr_q),
    .re_i    (cmd_i.rd_pf | cmd_i.rd_vf),
    .raddr_i (cmd_i.rd_vf ? lru_best_q : p_idx),
    .rdata_o (fr_rdata)
  );

  tlbm_ram #(.Width(TSW), .Depth(NP)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert | cmd_i.hit_upd),
    .waddr_i (p_idx),
    .wdata_i (now),
    .re_i    (lru_issue),
    .raddr_i (lru_addr_q[tlbm_pkg::PIDX_W-1:0]),
    .rdata_o (ts_rdata)
  );

  // status
  always_comb begin
    sts_o.is_start  = cmd_q;
    sts_o.bad       = (pg_q == '0) || (pg_q > limit);
    sts_o.hit       = |hit_vec;
    sts_o.pvalid    = pv_q[p_idx];
    sts_o.mod_done  = (fw_f_q < eff_frames);
    sts_o.fw_end    = (fw_cnt_q == eff_win);
    sts_o.fw_free   = ff_q[fw_f_q[tlbm_pkg::FIDX_W-1:0]];
    sts_o.lru_end   = (lru_addr_q == tlbm_pkg::PCNT_W'(NP)) && !lru_rv_q;
    sts_o.lru_found = lru_found_q;
    sts_o.tlb_full  = ($countones(tlb_v_q) >= 32'(cap));
    sts_o.ts_end    = (ts_idx_q == tlbm_pkg::TCNT_W'(NT));
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q    <= 6'd32;
      wst_q    <= 5'd0;
      wfr_q    <= 6'd1;
      tle_q    <= 5'd4;
      pcnt_q   <= 7'd64;
      tlb_v_q  <= '0;
      pv_q     <= '0;
      ff_q     <= '1;
      fault_q  <= '0;
      time_q   <= '0;
      fw_cnt_q <= '0;
      lru_addr_q  <= '0;
      lru_rv_q    <= 1'b0;
      lru_found_q <= 1'b0;
      ts_idx_q    <= '0;
      ts_found_q  <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tlbm_pkg::CFG_TOTAL_FRAMES:  tot_q  <= cfg_wdata_i[5:0];
          tlbm_pkg::CFG_WINDOW_START:  wst_q  <= cfg_wdata_i[4:0];
          tlbm_pkg::CFG_WINDOW_FRAMES: wfr_q  <= cfg_wdata_i[5:0];
          tlbm_pkg::CFG_TLB_ENTRIES:   tle_q  <= cfg_wdata_i[4:0];
          tlbm_pkg::CFG_PAGE_COUNT:    pcnt_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      done_o <= cmd_i.emit;
      if (cmd_i.fw_init) fw_cnt_q <= '0;
      if (cmd_i.fw_step || cmd_i.clr_free) fw_cnt_q <= fw_cnt_q + tlbm_pkg::FCNT_W'(1);
      if (cmd_i.clr_free) ff_q[fw_f_q[tlbm_pkg::FIDX_W-1:0]] <= 1'b1;
      if (cmd_i.claim) begin
        ff_q[fw_f_q[tlbm_pkg::FIDX_W-1:0]] <= 1'b0;
      end
      if ((cmd_i.claim || cmd_i.take_vf) && fault_q != '1) begin
        fault_q <= fault_q + tlbm_pkg::CNT_W'(1);
      end
      if (cmd_i.take_vf) begin
        pv_q[lru_best_q] <= 1'b0;
        tlb_v_q <= tlb_v_q & ~vmatch;
      end
      if (cmd_i.hit_upd) time_q <= now;
      if (cmd_i.lru_init) begin
        lru_addr_q  <= '0;
        lru_rv_q    <= 1'b0;
        lru_found_q <= 1'b0;
      end
      if (cmd_i.lru_step) begin
        lru_rv_q <= lru_issue;
        if (lru_issue) lru_addr_q <= lru_addr_q + tlbm_pkg::PCNT_W'(1);
        if (lru_rv_q && pv_q[lru_idx_q] && (!lru_found_q || ts_rdata < lru_bt_q)) begin
          lru_found_q <= 1'b1;
        end
      end
      if (cmd_i.ts_init) begin
        ts_idx_q   <= '0;
        ts_found_q <= 1'b0;
      end
      if (cmd_i.ts_step) begin
        ts_idx_q <= ts_idx_q + tlbm_pkg::TCNT_W'(1);
        if (tlb_v_q[ts_idx] && (!ts_found_q || tlb_ts_q[ts_idx] < ts_bt_q)) begin
          ts_found_q <= 1'b1;
        end
      end
      if (cmd_i.ts_drop && ts_found_q) tlb_v_q[ts_best_q] <= 1'b0;
      if (cmd_i.insert) begin
        pv_q[p_idx] <= 1'b1;
        time_q      <= now;
        if (ins_ok) tlb_v_q[ins_idx] <= 1'b1;
      end
      if (cmd_i.clr_proc) begin
        tlb_v_q <= '0;
        pv_q    <= '0;
        fault_q <= '0;
        time_q  <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_i.command;
      pg_q  <= in_i.page_number;
    end
    if (cmd_i.fw_init) fw_f_q <= tlbm_pkg::FW_W'(wst_q);
    if (cmd_i.mod_step) fw_f_q <= tlbm_pkg::FW_W'(fw_f_q - eff_frames);
    if (cmd_i.fw_step || cmd_i.clr_free) begin
      fw_f_q <= (fw_f_q + tlbm_pkg::FW_W'(1) == tlbm_pkg::FW_W'(eff_frames)) ? '0
              : fw_f_q + tlbm_pkg::FW_W'(1);
    end
    if (cmd_i.claim) begin
      fr_q   <= FRW'(fw_f_q + tlbm_pkg::FW_W'(1));
      vict_q <= '0;
      oc_q   <= tlbm_pkg::OC_FREE;
    end
    if (cmd_i.take_pf) begin
      fr_q   <= fr_rdata;
      vict_q <= '0;
      oc_q   <= tlbm_pkg::OC_MISS;
    end
    if (cmd_i.take_vf) begin
      fr_q   <= fr_rdata;
      vict_q <= lru_page;
      oc_q   <= tlbm_pkg::OC_EVICT;
    end
    if (cmd_i.lru_step) begin
      lru_idx_q <= lru_addr_q[tlbm_pkg::PIDX_W-1:0];
      if (lru_rv_q && pv_q[lru_idx_q] && (!lru_found_q || ts_rdata < lru_bt_q)) begin
        lru_best_q <= lru_idx_q;
        lru_bt_q   <= ts_rdata;
      end
    end
    if (cmd_i.ts_step) begin
      if (tlb_v_q[ts_idx] && (!ts_found_q || tlb_ts_q[ts_idx] < ts_bt_q)) begin
        ts_best_q <= ts_idx;
        ts_bt_q   <= tlb_ts_q[ts_idx];
      end
    end
    if (cmd_i.hit_upd) tlb_ts_q[hit_idx] <= now;
    if (cmd_i.insert && ins_ok) begin
      tlb_pg_q[ins_idx] <= pg_q;
      tlb_fr_q[ins_idx] <= fr_q;
      tlb_ts_q[ins_idx] <= now;
    end
    if (cmd_i.emit) begin
      result_o.outcome      <= cmd_i.insert ? oc_q : cmd_i.oc;
      result_o.frame_number <= cmd_i.hit_upd ? tlb_fr_q[hit_idx]
                             : (cmd_i.insert ? fr_q : '0);
      result_o.victim_page  <= cmd_i.insert ? vict_q : '0;
      result_o.fault_total  <= cmd_i.clr_proc ? '0 : fault_q;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/tlb_page_table_lru_mmu.sv
// TLB/page-table MMU with LRU replacement. A TLB hit or bad page is answered straight
// from the lookup; a fault walks the window (window_start mod total_frames reduction,
// then one window frame after another), then, with no free frame, an LRU search over
// the timestamp RAM, then a TLB LRU scan when the TLB is full. One transaction
// at a time; a new one may start on the cycle its predecessor's result is shown.
// Reset clears all valid bits and counters, config to defaults; frames all free.
`default_nettype none
module tlb_page_table_lru_mmu (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [tlbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tlbm_pkg::CFG_W-1:0]     cfg_wdata_i,
  // command side
  input  wire logic                           start_i,
  input  wire tlbm_pkg::in_t                  in_i,
  output logic                                busy_o,
  // result side: one-cycle strobe, receiver cannot stall
  output logic                                done_o,
  output tlbm_pkg::out_t                      result_o
);
  // controller drives commands, datapath reports status back
  tlbm_pkg::ctrl_cmd_t cmd;
  tlbm_pkg::ctrl_sts_t sts;

  tlbm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath holds TLB in flops, page frames and timestamps in RAMs
  tlbm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );
endmodule
`default_nettype wire

>>> rtl/core/tlbm_sva.sv
// Port-level checker for the TLB/page-table MMU, bound to the top level.
// Depends on tlbm_pkg and tlb_page_table_lru_mmu_assert.svh.
`default_nettype none
`include "tlb_page_table_lru_mmu_assert.svh"
module tlbm_sva (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire tlbm_pkg::in_t  in_i,
  input wire logic           busy_o,
  input wire logic           done_o,
  input wire tlbm_pkg::out_t result_o
);
  logic in_ok;
  assign in_ok = (in_i.page_number == in_i.page_number);

  `TLBM_ASSERT_NXT(a_accept_then_busy, start_i && !busy_o && in_ok, busy_o)
  `TLBM_ASSERT_NXT(a_single_strobe, done_o, !done_o)
  `TLBM_ASSERT_IMP(a_start_clean, done_o && result_o.outcome == 3'(tlbm_pkg::OC_START), result_o.fault_total == '0 && result_o.frame_number == '0)
  `TLBM_ASSERT_IMP(a_victim_only_evict, done_o && result_o.outcome != 3'(tlbm_pkg::OC_EVICT), result_o.victim_page == '0)
endmodule

bind tlb_page_table_lru_mmu tlbm_sva u_tlbm_sva (.*);
`default_nettype wire

>>> tb/tlb_page_table_lru_mmu_tb.sv
// Self-checking testbench for the TLB/page-table MMU with LRU replacement.
// Predicts each translation result in step with the block; needs tlbm_pkg and the RTL.
`default_nettype none
module tlb_page_table_lru_mmu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbm_pkg::*;

  localparam bit CMD_REF   = 1'b0;
  localparam bit CMD_START = 1'b1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 start_i = 1'b0;
  in_t                  in_i = '0;
  logic                 busy_o;
  logic                 done_o;
  out_t                 result_o;

  always #2 clk_i = ~clk_i;

  tlb_page_table_lru_mmu dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start_i, .in_i, .busy_o, .done_o, .result_o
  );

  // Shadow copy of the MMU: registers, page table, TLB, frame map, counters.
  int unsigned total_frames, window_start, window_frames, tlb_entries, page_count;
  logic [FRAME_W-1:0] pt_frame [MAX_PAGES];
  bit                 pt_valid [MAX_PAGES];
  logic [TS_W-1:0]    pt_stamp [MAX_PAGES];
  logic [PAGE_W-1:0]  tlb_pg   [TLB_DEPTH];
  logic [FRAME_W-1:0] tlb_fr   [TLB_DEPTH];
  bit                 tlb_v    [TLB_DEPTH];
  bit                 frame_free [MAX_FRAMES];
  logic [CNT_W-1:0]   faults;
  logic [TS_W-1:0]    ref_clock;

  out_t        pending_results [$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned oc_seen [8];

  function automatic int unsigned frames_eff();
    if (total_frames < 1) return 1;
    if (total_frames > MAX_FRAMES) return MAX_FRAMES;
    return total_frames;
  endfunction

  function automatic int unsigned window_len();
    return (window_frames < frames_eff()) ? window_frames : frames_eff();
  endfunction

  function automatic void clear_process();
    for (int i = 0; i < TLB_DEPTH; i++) begin
      tlb_v[i] = 0; tlb_pg[i] = '0; tlb_fr[i] = '0;
    end
    for (int i = 0; i < MAX_PAGES; i++) begin
      pt_valid[i] = 0; pt_frame[i] = '0; pt_stamp[i] = '0;
    end
    faults = '0;
    ref_clock = '0;
  endfunction

  function automatic void shadow_reset();
    total_frames = 32; window_start = 0; window_frames = 1;
    tlb_entries = 4; page_count = 64;
    clear_process();
    for (int i = 0; i < MAX_FRAMES; i++) frame_free[i] = 1;
  endfunction

  function automatic void tlb_fill(logic [PAGE_W-1:0] pg, logic [FRAME_W-1:0] fr);
    int unsigned used, cap, best;
    bit found;
    logic [TS_W-1:0] best_t, t;
    used = 0; found = 0; best = 0; best_t = '0;
    cap = (tlb_entries < 1) ? 1 : (tlb_entries > TLB_DEPTH) ? TLB_DEPTH : tlb_entries;
    for (int i = 0; i < TLB_DEPTH; i++) if (tlb_v[i]) used++;
    if (used >= cap) begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (tlb_v[i]) begin
          t = pt_stamp[(tlb_pg[i] - 1) % MAX_PAGES];
          if (!found || t < best_t) begin
            found = 1; best = i; best_t = t;
          end
        end
      end
      if (found) tlb_v[best] = 0;
    end
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (!tlb_v[i]) begin
        tlb_v[i] = 1; tlb_pg[i] = pg; tlb_fr[i] = fr;
        return;
      end
    end
  endfunction

  // Works out the result of one transaction and advances the shadow state.
  function automatic out_t translate(in_t item);
    out_t r;
    int unsigned lim, p, f, best;
    logic [TS_W-1:0] now, best_t;
    logic [FRAME_W-1:0] fr;
    logic [PAGE_W-1:0] victim;
    bit got, found;
    r = '0; fr = '0; victim = '0; got = 0; found = 0; best = 0; best_t = '0;
    lim = (page_count < MAX_PAGES) ? page_count : MAX_PAGES;
    if (item.command) begin
      clear_process();
      for (int i = 0; i < window_len(); i++)
        frame_free[(window_start + i) % frames_eff()] = 1;
      r.outcome = OC_START;
      return r;
    end
    r.outcome = OC_BAD;
    r.fault_total = faults;
    if (item.page_number == 0 || item.page_number > lim) return r;
    p = item.page_number - 1;
    now = (ref_clock == '1) ? ref_clock : ref_clock + 1;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (tlb_v[i] && tlb_pg[i] == item.page_number) begin
        ref_clock = now; pt_stamp[p] = now;
        r.outcome = OC_HIT; r.frame_number = tlb_fr[i];
        return r;
      end
    end
    if (pt_valid[p]) begin
      r.outcome = OC_MISS;
      fr = pt_frame[p];
    end else begin
      for (int i = 0; i < window_len() && !got; i++) begin
        f = (window_start + i) % frames_eff();
        if (frame_free[f]) begin
          frame_free[f] = 0; fr = FRAME_W'(f + 1); got = 1;
        end
      end
      if (got) begin
        r.outcome = OC_FREE;
      end else begin
        for (int i = 0; i < MAX_PAGES; i++) begin
          if (pt_valid[i] && (!found || pt_stamp[i] < best_t)) begin
            found = 1; best = i; best_t = pt_stamp[i];
          end
        end
        if (!found) return r;   // no frame to be had: answered as a bad page
        victim = PAGE_W'(best + 1);
        for (int i = 0; i < TLB_DEPTH; i++)
          if (tlb_v[i] && tlb_pg[i] == victim) tlb_v[i] = 0;
        pt_valid[best] = 0;
        fr = pt_frame[best];
        r.outcome = OC_EVICT;
      end
      pt_frame[p] = fr;
      pt_valid[p] = 1;
      if (faults != '1) faults++;
    end
    tlb_fill(item.page_number, fr);
    ref_clock = now; pt_stamp[p] = now;
    r.frame_number = fr;
    r.victim_page = victim;
    r.fault_total = faults;
    return r;
  endfunction

  // Result checker: the block cannot be held off, so every strobe is a transaction.
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, outcome %0d", result_o.outcome);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        oc_seen[exp_r.outcome]++;
        if (result_o.outcome !== exp_r.outcome) begin
          $error("outcome: expected %0d, got %0d", exp_r.outcome, result_o.outcome);
          fail_count++;
        end
        if (result_o.frame_number !== exp_r.frame_number) begin
          $error("frame_number: expected %0d, got %0d",
                 exp_r.frame_number, result_o.frame_number);
          fail_count++;
        end
        if (result_o.victim_page !== exp_r.victim_page) begin
          $error("victim_page: expected %0d, got %0d",
                 exp_r.victim_page, result_o.victim_page);
          fail_count++;
        end
        if (result_o.fault_total !== exp_r.fault_total) begin
          $error("fault_total: expected %0d, got %0d",
                 exp_r.fault_total, result_o.fault_total);
          fail_count++;
        end
      end
    end
  end

  // One transaction: random gap, raise start at a falling edge, hold until accepted.
  // With no gap, start stays high straight into the next transaction.
  // Prediction happens at the accepting edge so the queue is filled before the strobe.
  task automatic send_item(input bit cmd, input logic [PAGE_W-1:0] pg);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= '{command: cmd, page_number: pg};
    do @(posedge clk_i); while (busy_o);
    pending_results.insert(pending_results.size(),
                           translate('{command: cmd, page_number: pg}));
    sent_count++;
    @(negedge clk_i);
  endtask

  // Wait for the block to drain; no result is ever withheld, so an empty queue
  // plus a margin covering the longest fault walk means idle.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (140) @(negedge clk_i);
  endtask

  // One register write; the enable is dropped by set_config after the last one.
  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    @(negedge clk_i);
    case (idx)
      CFG_TOTAL_FRAMES:  total_frames  = value & 32'h3f;
      CFG_WINDOW_START:  window_start  = value & 32'h1f;
      CFG_WINDOW_FRAMES: window_frames = value & 32'h3f;
      CFG_TLB_ENTRIES:   tlb_entries   = value & 32'h1f;
      CFG_PAGE_COUNT:    page_count    = value & 32'h7f;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned tf, ws, wf, te, pc);
    wait_idle();
    write_reg(CFG_TOTAL_FRAMES, tf);
    write_reg(CFG_WINDOW_START, ws);
    write_reg(CFG_WINDOW_FRAMES, wf);
    write_reg(CFG_TLB_ENTRIES, te);
    write_reg(CFG_PAGE_COUNT, pc);
    cfg_we_i <= 1'b0;
  endtask

  // Reset values straight away: references to pages 1 and 2 with no free frame in window
  // beyond the first, then the page-range edges.
  task automatic test_reset_defaults();
    send_item(CMD_REF, 7'd1);
    send_item(CMD_REF, 7'd1);
    send_item(CMD_REF, 7'd2);   // single-frame window: evicts page 1
    send_item(CMD_REF, 7'd0);
    send_item(CMD_REF, 7'd64);
    send_item(CMD_REF, 7'd65);
    send_item(CMD_REF, 7'd127);
    send_item(CMD_START, 7'h7f);
  endtask

  // Small TLB, a few frames: hits, TLB misses without fault, free-frame faults,
  // evictions, and an empty window where no frame can be had.
  task automatic test_directed_paths();
    set_config(8, 6, 3, 1, 10);
    send_item(CMD_START, 7'd0);
    send_item(CMD_REF, 7'd1);
    send_item(CMD_REF, 7'd2);    // TLB of one entry drops page 1
    send_item(CMD_REF, 7'd1);    // page table still holds it
    send_item(CMD_REF, 7'd1);
    send_item(CMD_REF, 7'd3);
    send_item(CMD_REF, 7'd4);    // window full: LRU eviction
    send_item(CMD_REF, 7'd10);
    send_item(CMD_REF, 7'd11);
    set_config(5, 2, 0, 16, 4);
    send_item(CMD_START, 7'd0);
    send_item(CMD_REF, 7'd2);    // empty window, nothing valid
    // lower the TLB capacity below its fill
    set_config(32, 31, 32, 16, 64);
    send_item(CMD_START, 7'd0);
    for (int i = 1; i <= 6; i++) send_item(CMD_REF, i[PAGE_W-1:0]);
    set_config(32, 31, 32, 2, 64);
    send_item(CMD_REF, 7'd9);
  endtask

  // Random phases across register settings; mostly in-range pages from a small
  // working set so hits and evictions both occur, with some stray page numbers.
  task automatic test_random_workload();
    int unsigned tf, ws, wf, te, pc, set_pages;
    logic [PAGE_W-1:0] pg;
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: begin tf = 1; ws = 0; wf = 1; te = 1; pc = 1; end
        1: begin tf = 32; ws = 31; wf = 32; te = 16; pc = 64; end
        2: begin tf = 0; ws = 31; wf = 63; te = 0; pc = 127; end
        3: begin tf = 63; ws = 17; wf = 5; te = 31; pc = 0; end
        default: begin
          tf = $urandom_range(0, 63); ws = $urandom_range(0, 31);
          wf = $urandom_range(0, 63); te = $urandom_range(0, 31);
          pc = $urandom_range(0, 127);
        end
      endcase
      set_config(tf, ws, wf, te, pc);
      set_pages = $urandom_range(2, 24);
      send_item(CMD_START, PAGE_W'($urandom_range(0, 127)));
      for (int k = 0; k < 52; k++) begin
        case ($urandom_range(0, 19))
          0: send_item(CMD_START, PAGE_W'($urandom_range(0, 127)));
          1, 2: send_item(CMD_REF, PAGE_W'($urandom_range(0, 127)));
          default: begin
            pg = PAGE_W'($urandom_range(1, set_pages));
            send_item(CMD_REF, pg);
          end
        endcase
      end
    end
  endtask

  initial begin
    shadow_reset();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_paths();
    test_random_workload();
    wait_idle();
    $display("%0d transactions sent, %0d results checked over 16 register settings",
             sent_count, checked_count);
    $display("outcomes hit %0d miss %0d free %0d evict %0d bad %0d start %0d",
             oc_seen[0], oc_seen[1], oc_seen[2], oc_seen[3], oc_seen[4], oc_seen[5]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Worst case roughly 900 transactions, each a random gap plus a fault walk; allow many times that.
  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
